// File: rtl/fsc_pkg.sv
// Shared types, constants and the breakpoint search for the fuzzy steering controller.
package fsc_pkg;

  localparam int GRADES = 7;
  localparam int IDX_W  = 3;   // grade index
  localparam int X_W    = 17;  // error or rate value, signed
  localparam int D_W    = 10;  // distance to upper breakpoint and interval span
  localparam int RCP_W  = 25;  // floor(2^32 / span)
  localparam int MU_W   = 17;  // membership, 65536 = full
  localparam int CTR_W  = 11;  // output centre, signed
  localparam int PROD_W = 29;  // strength times centre, signed
  localparam int NUM_W  = 30;  // weighted sum, signed
  localparam int DEN_W  = 19;  // strength sum
  localparam int Q_W    = 10;  // quotient magnitude
  localparam int OUT_W  = 11;  // steering angle

  localparam logic [MU_W-1:0] MU_ONE = 17'd65536;

  typedef logic signed [X_W-1:0]   pt_t;
  typedef pt_t                     pts_t [GRADES];
  typedef logic [RCP_W-1:0]        rcp_tab_t [GRADES-1];
  typedef logic [IDX_W-1:0]        rule_row_t [GRADES];
  typedef rule_row_t               rule_tab_t [GRADES];
  typedef logic signed [CTR_W-1:0] ctr_tab_t [GRADES];

  // Breakpoints in Q11.4 degrees
  localparam pts_t ERR_PTS = '{
    -17'sd720, -17'sd480, -17'sd240, 17'sd0, 17'sd240, 17'sd480, 17'sd720
  };
  localparam pts_t RATE_PTS = '{
    -17'sd1440, -17'sd1120, -17'sd640, 17'sd0, 17'sd640, 17'sd1120, 17'sd1440
  };

  // floor(2^32 / span) for each interval
  localparam rcp_tab_t ERR_RCP = '{
    25'd17895697, 25'd17895697, 25'd17895697,
    25'd17895697, 25'd17895697, 25'd17895697
  };
  localparam rcp_tab_t RATE_RCP = '{
    25'd13421772, 25'd8947848, 25'd6710886,
    25'd6710886, 25'd8947848, 25'd13421772
  };

  // Rule table, row = error grade, column = rate grade, entry = output grade index
  localparam rule_tab_t RULE_TAB = '{
    '{3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd2},
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4},
    '{3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4},
    '{3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5},
    '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5},
    '{3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6},
    '{3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6}
  };

  // Output centres in 1/16 degree
  localparam ctr_tab_t CENTRES = '{
    -11'sd960, -11'sd720, -11'sd360, 11'sd0, 11'sd360, 11'sd720, 11'sd960
  };

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [D_W-1:0]   d;
    logic [D_W-1:0]   span;
    logic [RCP_W-1:0] rcp;
  } fuzz_t;

  // Interval search: lower grade, distance to the upper breakpoint and span.
  // Below range: d = span gives full lower membership; above range: d = 0.
  function automatic fuzz_t fuzz_locate(input pt_t x, input pts_t pts,
                                        input rcp_tab_t rcp);
    fuzz_t            f;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] hi;
    c = '0;
    for (int k = 0; k < GRADES; k++) begin
      if (x >= pts[k]) c = IDX_W'(k + 1);
    end
    if (c == '0) begin
      f.lo = '0;
    end else if (c == IDX_W'(GRADES)) begin
      f.lo = IDX_W'(GRADES - 2);
    end else begin
      f.lo = c - 1'b1;
    end
    hi     = f.lo + 1'b1;
    f.span = D_W'(pts[hi] - pts[f.lo]);
    f.rcp  = rcp[f.lo];
    if (c == '0) begin
      f.d = f.span;
    end else if (c == IDX_W'(GRADES)) begin
      f.d = '0;
    end else begin
      f.d = D_W'(pts[c] - x);
    end
    return f;
  endfunction

endpackage

// File: rtl/fsc_memb.sv
// Two-stage membership unit: d * 65536 / span by reciprocal multiply and one correction.
module fsc_memb
  import fsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  fuzz_t            fz_i,
  output logic [IDX_W-1:0] lo_o,
  output logic [MU_W-1:0]  mu_o
);

  logic [D_W+RCP_W-1:0] prod;
  logic [MU_W-1:0]      est_d, est_q;
  logic [D_W-1:0]       d_q, span_q;
  logic [IDX_W-1:0]     lo_b_q;
  logic [25:0]          num_c, back_c, rem_c;
  logic [MU_W-1:0]      mu_d;

  // Estimate, low by at most one
  assign prod  = D_W'(fz_i.d) * fz_i.rcp;
  assign est_d = MU_W'(prod >> 16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      est_q  <= est_d;
      d_q    <= fz_i.d;
      span_q <= fz_i.span;
      lo_b_q <= fz_i.lo;
    end
  end

  // Remainder check fixes the estimate
  assign num_c  = {d_q, 16'b0};
  assign back_c = 26'(est_q * span_q);
  assign rem_c  = num_c - back_c;
  assign mu_d   = (rem_c >= 26'(span_q)) ? est_q + 1'b1 : est_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mu_o <= mu_d;
      lo_o <= lo_b_q;
    end
  end

endmodule

// File: rtl/fsc_rules.sv
// Rule evaluation, duplicate-grade pruning and weighted sums, three stages.
module fsc_rules
  import fsc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [IDX_W-1:0]        elo_i,
  input  logic [MU_W-1:0]         emu_i,
  input  logic [IDX_W-1:0]        rlo_i,
  input  logic [MU_W-1:0]         rmu_i,
  output logic signed [NUM_W-1:0] num_o,
  output logic [DEN_W-1:0]        den_o
);

  logic [MU_W-1:0]          emu [2];
  logic [MU_W-1:0]          rmu [2];
  logic [MU_W-1:0]          str [4];
  logic [IDX_W-1:0]         grd [4];
  logic [MU_W-1:0]          str_q [4];
  logic signed [CTR_W-1:0]  ctr_q [4];
  logic signed [PROD_W-1:0] prod_q [4];
  logic [DEN_W-1:0]         den_q;
  logic signed [NUM_W-1:0]  num_d;

  // Rule strengths and output grades, equal grades keep only the larger
  always_comb begin
    emu[0] = emu_i;
    emu[1] = MU_ONE - emu_i;
    rmu[0] = rmu_i;
    rmu[1] = MU_ONE - rmu_i;
    for (int i = 0; i < 4; i++) begin
      grd[i] = RULE_TAB[elo_i + IDX_W'(i & 1)][rlo_i + IDX_W'((i >> 1) & 1)];
      str[i] = (emu[i & 1] <= rmu[(i >> 1) & 1]) ? emu[i & 1] : rmu[(i >> 1) & 1];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (grd[i] == grd[j]) begin
          if (str[i] > str[j]) str[j] = '0;
          else                 str[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        str_q[i] <= str[i];
        ctr_q[i] <= CENTRES[grd[i]];
      end
    end
  end

  // Products and strength sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= PROD_W'($signed({1'b0, str_q[i]}) * ctr_q[i]);
      end
      den_q <= DEN_W'(str_q[0]) + DEN_W'(str_q[1]) + DEN_W'(str_q[2]) + DEN_W'(str_q[3]);
    end
  end

  // Weighted sum
  assign num_d = NUM_W'(prod_q[0]) + NUM_W'(prod_q[1]) + NUM_W'(prod_q[2])
               + NUM_W'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_d;
      den_o <= den_q;
    end
  end

endmodule

// File: rtl/fsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncates toward zero.
module fsc_div
  import fsc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic signed [OUT_W-1:0] q_o
);

  logic [NUM_W-1:0] rem_q  [Q_W+1];
  logic [Q_W-1:0]   quo_q  [Q_W+1];
  logic [DEN_W-1:0] den_q  [Q_W+1];
  logic             neg_q  [Q_W+1];
  logic             zero_q [Q_W+1];

  // Magnitude and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= num_i[NUM_W-1];
      zero_q[0] <= (den_i == '0);
    end
  end

  // One quotient bit per stage, MSB first
  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [NUM_W-1:0] trial;
    logic             take;
    assign trial = NUM_W'(den_q[s]) << (Q_W - 1 - s);
    assign take  = (rem_q[s] >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? rem_q[s] - trial : rem_q[s];
        quo_q[s+1]  <= {quo_q[s][Q_W-2:0], take};
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  // Apply sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[Q_W])     q_o <= '0;
      else if (neg_q[Q_W]) q_o <= -$signed({1'b0, quo_q[Q_W]});
      else                 q_o <= $signed({1'b0, quo_q[Q_W]});
    end
  end

endmodule

// File: rtl/fuzzy_steering_controller.sv
// Fuzzy PD steering controller top level: front stage, valid tracking, unit hookup.
//
// One item (current and previous track error, signed Q11.4 degrees) enters per clock while
// not stalled and gives one steering angle in 1/16 degree. Stages: breakpoint search (1),
// membership by reciprocal multiply (2), rule evaluation and weighted sums (3), and a
// one-bit-per-stage divider with sign handling (12). The whole pipeline freezes while a
// finished result is stalled at the output; bubbles travel as cleared valid bits.
module fuzzy_steering_controller
  import fsc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [15:0]      error_now_i,
  input  logic signed [15:0]      error_before_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] steer_angle_o
);

  localparam int LAT = 18;

  logic                    en;
  logic [LAT-1:0]          vld_q;
  pt_t                     e_x, r_x;
  fuzz_t                   efz_q, rfz_q;
  logic [IDX_W-1:0]        elo, rlo;
  logic [MU_W-1:0]         emu, rmu;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;

  // Global advance: hold everything while the output item waits
  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Error, rate and interval search
  assign e_x = pt_t'(error_now_i);
  assign r_x = pt_t'(error_now_i) - pt_t'(error_before_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      efz_q <= fuzz_locate(e_x, ERR_PTS, ERR_RCP);
      rfz_q <= fuzz_locate(r_x, RATE_PTS, RATE_RCP);
    end
  end

  fsc_memb u_memb_err (
    .clk_i (clk_i),
    .en_i  (en),
    .fz_i  (efz_q),
    .lo_o  (elo),
    .mu_o  (emu)
  );

  fsc_memb u_memb_rate (
    .clk_i (clk_i),
    .en_i  (en),
    .fz_i  (rfz_q),
    .lo_o  (rlo),
    .mu_o  (rmu)
  );

  fsc_rules u_rules (
    .clk_i (clk_i),
    .en_i  (en),
    .elo_i (elo),
    .emu_i (emu),
    .rlo_i (rlo),
    .rmu_i (rmu),
    .num_o (num),
    .den_o (den)
  );

  fsc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num),
    .den_i (den),
    .q_o   (steer_angle_o)
  );

endmodule

// File: tb/tb_fuzzy_steering_controller.sv
// Testbench for the fuzzy steering controller: directed and random error pairs, checked by a predictor.
module tb_fuzzy_steering_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import fsc_pkg::*;

  localparam int LIMIT = 400000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [15:0]      error_now_i;
  logic signed [15:0]      error_before_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [OUT_W-1:0] steer_angle_o;

  logic signed [OUT_W-1:0] angle_q [$];
  int  fail_cnt;
  int  cycle_cnt;
  bit  calm;  // no idling on either side

  fuzzy_steering_controller dut (.*);

  // Clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Lower grade and its membership on a breakpoint set
  function automatic void grade_of(input int x, input int p [7], output int lo,
                                   output longint mu);
    int i;
    i = 0;
    while (i < 7 && x >= p[i]) i++;
    if (i == 0) begin
      lo = 0; mu = 65536;
    end else if (i == 7) begin
      lo = 5; mu = 0;
    end else begin
      lo = i - 1;
      mu = (longint'(p[i] - x) * 65536) / (p[i] - p[i-1]);
    end
  endfunction

  // Expected steering angle for one error pair
  function automatic logic signed [OUT_W-1:0] steer_of(int e, int eb);
    int err_p [7] = '{-720, -480, -240, 0, 240, 480, 720};
    int rate_p [7] = '{-1440, -1120, -640, 0, 640, 1120, 1440};
    int ctr [7] = '{-960, -720, -360, 0, 360, 720, 960};
    int rules [7][7] = '{
      '{0, 0, 0, 1, 2, 2, 2}, '{0, 0, 1, 1, 2, 3, 4}, '{1, 1, 2, 2, 3, 4, 4},
      '{1, 2, 2, 3, 3, 4, 5}, '{2, 2, 3, 4, 4, 5, 5}, '{2, 3, 4, 4, 5, 6, 6},
      '{3, 4, 4, 5, 6, 6, 6}};
    int elo, rlo;
    longint emu [2], rmu [2], str [4], num, den;
    int g [4];
    grade_of(e, err_p, elo, emu[0]);
    emu[1] = 65536 - emu[0];
    grade_of(e - eb, rate_p, rlo, rmu[0]);
    rmu[1] = 65536 - rmu[0];
    for (int i = 0; i < 4; i++) begin
      g[i] = rules[elo + (i & 1)][rlo + (i >> 1)];
      str[i] = (emu[i & 1] <= rmu[i >> 1]) ? emu[i & 1] : rmu[i >> 1];
    end
    // same output grade: keep only the stronger rule, the later one on a tie
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        if (g[i] == g[j]) begin
          if (str[i] > str[j]) str[j] = 0;
          else str[i] = 0;
        end
    num = 0; den = 0;
    for (int i = 0; i < 4; i++) begin
      num += str[i] * ctr[g[i]];
      den += str[i];
    end
    return (den > 0) ? OUT_W'(num / den) : '0;
  endfunction

  // Drive one item and wait for its acceptance
  task automatic send_pair(input logic signed [15:0] e, input logic signed [15:0] eb);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    error_now_i    <= e;
    error_before_i <= eb;
    angle_q.push_back(steer_of(e, eb));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Extremes, breakpoints and out-of-range values
  task automatic test_directed();
    send_pair(16'sh7FFF, -16'sh8000);
    send_pair(-16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(-16'sh8000, -16'sh8000);
    send_pair(0, 0);
    send_pair(720, 0);
    send_pair(-720, 720);
    send_pair(240, -400);
    send_pair(-240, 400);
    send_pair(480, -960);
    send_pair(-480, 640);
    send_pair(-721, -721);
    send_pair(721, -719);
    send_pair(100, 740);
    send_pair(-100, -1220);
    send_pair(16'shFFFF, 16'sh0001);
    send_pair(16'sh5555, 16'shAAAA);
    send_pair(16'shAAAA, 16'sh5555);
    go_idle();
  endtask

  // Mostly in-range pairs, some full-range noise
  task automatic test_random();
    int e, eb;
    for (int n = 0; n < 1600; n++) begin
      calm = (n >= 600 && n < 800);
      if ($urandom_range(9) < 8) begin
        e  = $urandom_range(1700) - 850;
        eb = e - ($urandom_range(3200) - 1600);
        if (eb > 32767) eb = 32767;
        if (eb < -32768) eb = -32768;
      end else begin
        e  = $signed(16'($urandom));
        eb = $signed(16'($urandom));
      end
      send_pair(16'(e), 16'(eb));
    end
    calm = 1'b0;
    go_idle();
  endtask

  // Output stall and result check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (angle_q.size() == 0) begin
          $error("steer_angle: unexpected result %0d", steer_angle_o);
          fail_cnt++;
        end else begin
          if (steer_angle_o !== angle_q[0]) begin
            $error("steer_angle: expected %0d, actual %0d", angle_q[0], steer_angle_o);
            fail_cnt++;
          end
          void'(angle_q.pop_front());
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 36);
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    error_now_i = '0;
    error_before_i = '0;
    out_stall_i = 1'b0;
    fail_cnt = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && angle_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
